@@ rtl/bmp_stream_decoder_core_assert.svh @@
// Assertion macros for the bitmap stream decoder.
// Included by the top level; needs no package.
`ifndef BMP_STREAM_DECODER_CORE_ASSERT_SVH
`define BMP_STREAM_DECODER_CORE_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define BMPSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bmpsd implication check failed");

// Implication whose consequence is checked on the following edge.
`define BMPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bmpsd next-cycle check failed");

`endif

@@ rtl/bmpsd_pkg.sv @@
// Shared types and constants for the bitmap stream decoder.
// No dependencies.
`default_nettype none

package bmpsd_pkg;

	typedef logic [2:0] phase_t;
	typedef logic [2:0] kind_t;

	// decoder phases
	localparam phase_t PH_IDLE   = 3'd0;
	localparam phase_t PH_HEADER = 3'd1;
	localparam phase_t PH_DATA   = 3'd2;
	localparam phase_t PH_PAD    = 3'd3;
	localparam phase_t PH_DONE   = 3'd4;

	// result kinds
	localparam kind_t KIND_PIXEL      = 3'd0;
	localparam kind_t KIND_HDR_DONE   = 3'd1;
	localparam kind_t KIND_BAD_SIG    = 3'd2;
	localparam kind_t KIND_BAD_SIZE   = 3'd3;
	localparam kind_t KIND_BAD_DEPTH  = 3'd4;
	localparam kind_t KIND_BAD_OFFSET = 3'd5;

	// header geometry
	localparam int unsigned HEADER_BYTES = 54;
	localparam logic [31:0] POS_SIG    = 32'd1;
	localparam logic [31:0] POS_SIZE   = 32'd5;
	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_WIDTH  = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_DEPTH  = 32'd29;
	localparam logic [31:0] POS_RES_X  = 32'd41;
	localparam logic [31:0] POS_RES_Y  = 32'd45;
	localparam logic [31:0] POS_LAST   = 32'(HEADER_BYTES - 1);
	localparam logic [31:0] MIN_OFFSET = 32'(HEADER_BYTES);

	localparam logic [7:0]  CHAR_B   = 8'h42;
	localparam logic [7:0]  CHAR_M   = 8'h4D;
	localparam logic [15:0] DEPTH_24 = 16'd24;
	localparam logic [15:0] DEPTH_32 = 16'd32;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

`default_nettype wire

@@ rtl/bmp_stream_decoder_core.sv @@
// Bitmap stream decoder: one input beat per cycle unless in_stall holds it; a byte taken
// into the input register is decoded into the result register once the result slot is
// free. Throughput is one byte per cycle while the result is not stalled, set by the single-pass
// next-state logic. A stalled result stalls the input only while the input register is also full.
// arst_n clears the control state, the file-size register and both valid flags;
// after reset bytes are ignored until a beat with file_start.
`default_nettype none

module bmp_stream_decoder_core
	import bmpsd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         expected_file_size_we,
	input  wire  [31:0] expected_file_size,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         file_start,
	// result channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  kind,
	output logic [31:0] pixel_word,
	output logic signed [31:0] image_width,
	output logic signed [31:0] image_height,
	output logic [15:0] color_depth,
	output logic [31:0] horizontal_resolution,
	output logic [31:0] vertical_resolution,
	output logic [31:0] pixel_offset,
	output logic        last_pixel
);

	`include "bmp_stream_decoder_core_assert.svh"

	// config register
	logic [31:0] exp_size_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// decoder state
	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] fa_q, fa_d;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [15:0] depth_q, depth_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] resx_q, resx_d;
	logic [31:0] resy_q, resy_d;
	logic [31:0] rows_q, rows_d;
	logic [31:0] row_q, row_d;
	logic [31:0] col_q, col_d;
	logic [1:0]  bip_q, bip_d;
	logic [23:0] acc_q, acc_d;
	logic [1:0]  pad_q, pad_d;

	// step results
	logic        emit;
	kind_t       kind_d;
	logic [31:0] word_d;
	logic        last_d;

	// output register
	logic        out_valid_q;
	kind_t       kind_q;
	logic [31:0] word_q;
	logic [31:0] width_out_q;
	logic [31:0] height_out_q;
	logic [15:0] depth_out_q;
	logic [31:0] resx_out_q;
	logic [31:0] resy_out_q;
	logic [31:0] offset_out_q;
	logic        last_q;

	logic slot_free;
	logic adv;

	assign slot_free = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && slot_free;
	assign in_stall  = valid_s1 && !slot_free;

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_size_q <= '0;
		end else if (expected_file_size_we) begin
			exp_size_q <= expected_file_size;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	// next-state logic for one byte
	always_comb begin
		logic [31:0] pos_inc;
		logic [31:0] col_next;
		logic [31:0] row_next;
		logic [1:0]  last_bip;

		phase_d  = phase_q;
		pos_d    = pos_q;
		fa_d     = fa_q;
		width_d  = width_q;
		height_d = height_q;
		depth_d  = depth_q;
		offset_d = offset_q;
		resx_d   = resx_q;
		resy_d   = resy_q;
		rows_d   = rows_q;
		row_d    = row_q;
		col_d    = col_q;
		bip_d    = bip_q;
		acc_d    = acc_q;
		pad_d    = pad_q;
		emit     = 1'b0;
		kind_d   = KIND_PIXEL;
		word_d   = '0;
		last_d   = 1'b0;

		// file start drops the old file
		if (start_s1) begin
			phase_d  = PH_HEADER;
			pos_d    = '0;
			fa_d     = '0;
			width_d  = '0;
			height_d = '0;
			depth_d  = '0;
			offset_d = '0;
			resx_d   = '0;
			resy_d   = '0;
			rows_d   = '0;
			row_d    = '0;
			col_d    = '0;
			bip_d    = '0;
			acc_d    = '0;
			pad_d    = '0;
		end

		// saturating byte position
		pos_inc  = (pos_d != '1) ? pos_d + 32'd1 : pos_d;
		col_next = col_d + 32'd1;
		row_next = row_d + 32'd1;
		last_bip = (depth_d == DEPTH_32) ? 2'd3 : 2'd2;

		case (phase_d)
			PH_HEADER: begin
				fa_d = {byte_s1, fa_d[31:8]};
				case (pos_d)
					POS_SIG: begin
						if (fa_d[23:16] != CHAR_B || byte_s1 != CHAR_M) begin
							emit = 1'b1; kind_d = KIND_BAD_SIG; phase_d = PH_DONE;
						end
					end
					POS_SIZE: begin
						if (fa_d != exp_size_q) begin
							emit = 1'b1; kind_d = KIND_BAD_SIZE; phase_d = PH_DONE;
						end
					end
					POS_OFFSET: offset_d = fa_d;
					POS_WIDTH:  width_d  = fa_d;
					POS_HEIGHT: begin
						height_d = fa_d;
						// row total is abs(height)
						rows_d   = fa_d[31] ? (32'd0 - fa_d) : fa_d;
					end
					POS_DEPTH: begin
						depth_d = fa_d[31:16];
						if (depth_d != DEPTH_24 && depth_d != DEPTH_32) begin
							emit = 1'b1; kind_d = KIND_BAD_DEPTH; phase_d = PH_DONE;
						end
					end
					POS_RES_X: resx_d = fa_d;
					POS_RES_Y: resy_d = fa_d;
					POS_LAST: begin
						emit = 1'b1;
						if (offset_d < MIN_OFFSET) begin
							kind_d  = KIND_BAD_OFFSET;
							phase_d = PH_DONE;
						end else begin
							kind_d = KIND_HDR_DONE;
							if (width_d[31] || width_d == '0 || height_d == '0) begin
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_DATA;
							end
						end
					end
					default: ;
				endcase
				pos_d = pos_inc;
			end
			PH_DATA: begin
				if (pos_d >= offset_d) begin
					if (bip_d < last_bip) begin
						acc_d = acc_d | (24'(byte_s1) << {bip_d, 3'b000});
						bip_d = bip_d + 2'd1;
					end else begin
						if (depth_d == DEPTH_32) begin
							word_d = {byte_s1, acc_d};
						end else begin
							word_d = {ALPHA_OPAQUE, byte_s1, acc_d[15:0]};
						end
						emit   = 1'b1;
						kind_d = KIND_PIXEL;
						bip_d  = '0;
						acc_d  = '0;
						// end of row / end of image
						if (col_next == width_d) begin
							col_d = '0;
							row_d = row_next;
							if (row_next == rows_d) begin
								last_d  = 1'b1;
								phase_d = PH_DONE;
							end else if (depth_d == DEPTH_24 && width_d[1:0] != 2'd0) begin
								pad_d   = width_d[1:0];
								phase_d = PH_PAD;
							end
						end else begin
							col_d = col_next;
						end
					end
				end
				pos_d = pos_inc;
			end
			PH_PAD: begin
				pad_d = pad_d - 2'd1;
				if (pad_d == 2'd0) begin
					phase_d = PH_DATA;
				end
				pos_d = pos_inc;
			end
			default: ;
		endcase
	end

	// decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			fa_q     <= '0;
			width_q  <= '0;
			height_q <= '0;
			depth_q  <= '0;
			offset_q <= '0;
			resx_q   <= '0;
			resy_q   <= '0;
			rows_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			bip_q    <= '0;
			acc_q    <= '0;
			pad_q    <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			fa_q     <= fa_d;
			width_q  <= width_d;
			height_q <= height_d;
			depth_q  <= depth_d;
			offset_q <= offset_d;
			resx_q   <= resx_d;
			resy_q   <= resy_d;
			rows_q   <= rows_d;
			row_q    <= row_d;
			col_q    <= col_d;
			bip_q    <= bip_d;
			acc_q    <= acc_d;
			pad_q    <= pad_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q       <= kind_d;
			word_q       <= word_d;
			width_out_q  <= width_d;
			height_out_q <= height_d;
			depth_out_q  <= depth_d;
			resx_out_q   <= resx_d;
			resy_out_q   <= resy_d;
			offset_out_q <= offset_d;
			last_q       <= last_d;
		end
	end

	assign out_valid             = out_valid_q;
	assign kind                  = kind_q;
	assign pixel_word            = word_q;
	assign image_width           = signed'(width_out_q);
	assign image_height          = signed'(height_out_q);
	assign color_depth           = depth_out_q;
	assign horizontal_resolution = resx_out_q;
	assign vertical_resolution   = resy_out_q;
	assign pixel_offset          = offset_out_q;
	assign last_pixel            = last_q;

	// checks
	`BMPSD_ASSERT_IMP(a_last_is_pixel, clk, arst_n, out_valid_q && last_q, kind_q == KIND_PIXEL)
	`BMPSD_ASSERT_IMP(a_word_only_pixel, clk, arst_n, out_valid_q && kind_q != KIND_PIXEL, word_q == '0)
	`BMPSD_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid_q, kind_q <= KIND_BAD_OFFSET)
	`BMPSD_ASSERT_NEXT(a_data_after_header, clk, arst_n, adv && phase_d == PH_DATA, depth_q == DEPTH_24 || depth_q == DEPTH_32)

endmodule

`default_nettype wire
